@@ sv/dlps_pkg.sv @@
// Shared types and constants for the debounced LED pattern sequencer.
// No dependencies; imported by every module of the block.
package dlps_pkg;

  localparam int unsigned NumButtons = 3;

  // configuration register indexes
  localparam logic [1:0] REG_TICK_PRESCALE  = 2'd0;
  localparam logic [1:0] REG_SLOW_DIVISOR   = 2'd1;
  localparam logic [1:0] REG_FAST_DIVISOR   = 2'd2;
  localparam logic [1:0] REG_DEBOUNCE_LIMIT = 2'd3;

  // configuration reset values
  localparam logic [7:0] RST_TICK_PRESCALE  = 8'd250;
  localparam logic [7:0] RST_SLOW_DIVISOR   = 8'd16;
  localparam logic [7:0] RST_FAST_DIVISOR   = 8'd8;
  localparam logic [3:0] RST_DEBOUNCE_LIMIT = 4'd4;

  // input opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // pattern modes
  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_BLINK    = 3'd1;
  localparam logic [2:0] MODE_WALK     = 3'd2;
  localparam logic [2:0] MODE_CONVERGE = 3'd3;
  localparam logic [2:0] MODE_FILL     = 3'd4;

  // mask seeds and turn points
  localparam logic [7:0] SEED_LEFT     = 8'h01;
  localparam logic [7:0] SEED_RIGHT    = 8'h80;
  localparam logic [7:0] SEED_FILL     = 8'h40;
  localparam logic [7:0] RESEED_LEFT   = 8'h02;
  localparam logic [7:0] RESEED_RIGHT  = 8'h40;
  localparam logic [7:0] CONV_PIVOT    = 8'h10;
  localparam logic [7:0] FILL_TURN     = 8'h1F;
  localparam logic [7:0] WALK_LAST     = 8'h80;

  typedef struct packed {
    logic [7:0] tick_prescale;
    logic [7:0] slow_divisor;
    logic [7:0] fast_divisor;
    logic [3:0] debounce_limit;
  } cfg_t;

  typedef struct packed {
    logic run;
    logic speed;
    logic mode;
  } btn_edge_t;

endpackage

@@ sv/dlps_debounce.sv @@
// Debouncer for one button with falling-edge detect on the adopted level.
// Depends on dlps_pkg.
module dlps_debounce (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       sample_i,
  input  logic       raw_i,
  input  logic [3:0] limit_i,
  output logic       fall_o
);
  import dlps_pkg::*;

  logic       raw_prev_q, raw_prev_d;
  logic       level_q, level_d;
  logic       level_prev_q, level_prev_d;
  logic [3:0] count_q, count_d;
  logic [3:0] count_inc;

  assign count_inc = count_q + 4'd1;

  always_comb begin
    raw_prev_d   = raw_prev_q;
    level_d      = level_q;
    level_prev_d = level_prev_q;
    count_d      = count_q;
    fall_o       = 1'b0;
    if (sample_i) begin
      if (raw_prev_q != raw_i) begin
        count_d = '0;
      end else if (count_inc > limit_i) begin
        level_d = raw_i;
        count_d = '0;
      end else begin
        count_d = count_inc;
      end
      fall_o       = level_prev_q & ~level_d;
      level_prev_d = level_d;
      raw_prev_d   = raw_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_prev_q   <= 1'b0;
      level_q      <= 1'b0;
      level_prev_q <= 1'b0;
      count_q      <= '0;
    end else begin
      raw_prev_q   <= raw_prev_d;
      level_q      <= level_d;
      level_prev_q <= level_prev_d;
      count_q      <= count_d;
    end
  end

endmodule

@@ sv/dlps_core.sv @@
// Timer divider chain, run/speed flags and LED pattern state.
// Depends on dlps_pkg; its state registers drive the result fields directly.
module dlps_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_en_i,
  input  logic              opcode_i,
  input  dlps_pkg::btn_edge_t edge_i,
  input  dlps_pkg::cfg_t    cfg_i,
  output logic [7:0]        led_o,
  output logic              run_o,
  output logic              fast_o,
  output logic [2:0]        mode_o
);
  import dlps_pkg::*;

  logic [7:0] led_q, led_d;
  logic [2:0] mode_q, mode_d;
  logic       run_q, run_d;
  logic       fast_q, fast_d;
  logic [7:0] lmask_q, lmask_d;
  logic [7:0] rmask_q, rmask_d;
  logic [7:0] fill_q, fill_d;
  logic       rev_q, rev_d;
  logic [7:0] presc_q, presc_d;
  logic [7:0] div_q, div_d;

  logic [7:0] presc_inc, div_inc, div_limit;
  logic [7:0] lm_cur, rm_cur;
  logic       rev_cur;

  assign presc_inc = presc_q + 8'd1;
  assign div_inc   = div_q + 8'd1;
  assign div_limit = fast_q ? cfg_i.fast_divisor : cfg_i.slow_divisor;

  always_comb begin
    led_d   = led_q;
    mode_d  = mode_q;
    run_d   = run_q;
    fast_d  = fast_q;
    lmask_d = lmask_q;
    rmask_d = rmask_q;
    fill_d  = fill_q;
    rev_d   = rev_q;
    presc_d = presc_q;
    div_d   = div_q;
    lm_cur  = lmask_q;
    rm_cur  = rmask_q;
    rev_cur = rev_q;
    if (step_en_i) begin
      if (opcode_i == OP_SAMPLE) begin
        if (edge_i.run) begin
          run_d = ~run_q;
        end
        if (edge_i.speed) begin
          fast_d = ~fast_q;
        end
        if (edge_i.mode) begin
          led_d  = '0;
          mode_d = (mode_q >= MODE_FILL) ? MODE_BLINK : mode_q + 3'd1;
          if (mode_d == MODE_CONVERGE) begin
            lmask_d = SEED_LEFT;
            rmask_d = SEED_RIGHT;
          end else if (mode_d == MODE_FILL) begin
            rev_d   = 1'b0;
            fill_d  = SEED_FILL;
            lmask_d = SEED_LEFT;
            rmask_d = SEED_RIGHT;
          end
        end
      end else begin
        presc_d = presc_inc;
        if (presc_inc >= cfg_i.tick_prescale) begin
          presc_d = '0;
          div_d   = div_inc;
          if (div_inc >= div_limit) begin
            div_d = '0;
            if (!run_q) begin
              led_d  = '0;
              mode_d = MODE_IDLE;
            end else begin
              case (mode_q)
                MODE_BLINK: begin
                  led_d = ~led_q;
                end
                MODE_WALK: begin
                  if (led_q == 8'h00 || (led_q & WALK_LAST) != 8'h00) begin
                    led_d = SEED_LEFT;
                  end else begin
                    led_d = {led_q[6:0], 1'b0};
                  end
                end
                MODE_CONVERGE: begin
                  // skip the crossing point in the middle
                  if (lmask_q == CONV_PIVOT) begin
                    lm_cur = {lmask_q[6:0], 1'b0};
                    rm_cur = rmask_q >> 1;
                  end
                  led_d   = lm_cur | rm_cur;
                  lmask_d = {lm_cur[6:0], 1'b0};
                  rmask_d = rm_cur >> 1;
                  if (lmask_d == 8'h00) begin
                    lmask_d = RESEED_LEFT;
                    rmask_d = RESEED_RIGHT;
                  end
                end
                MODE_FILL: begin
                  if (lmask_q == 8'h00) begin
                    rmask_d = SEED_RIGHT;
                    fill_d  = SEED_FILL;
                    lmask_d = SEED_LEFT;
                    led_d   = '0;
                    rev_d   = 1'b0;
                  end else begin
                    // full bar reached: turn around and start emptying
                    if (lmask_q == FILL_TURN) begin
                      rev_cur = 1'b1;
                      rm_cur  = {rmask_q[5:0], 2'b00};
                      lm_cur  = lmask_q >> 2;
                    end
                    led_d = lm_cur | rm_cur;
                    rev_d = rev_cur;
                    if (!rev_cur) begin
                      lmask_d = {lm_cur[6:0], 1'b1};
                      rmask_d = rm_cur | fill_q;
                      fill_d  = fill_q >> 1;
                    end else begin
                      lmask_d = lm_cur >> 1;
                      rmask_d = {rm_cur[6:0], 1'b0};
                    end
                  end
                end
                default: begin
                  led_d = led_q;
                end
              endcase
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q   <= '0;
      mode_q  <= MODE_IDLE;
      run_q   <= 1'b0;
      fast_q  <= 1'b0;
      lmask_q <= '0;
      rmask_q <= '0;
      fill_q  <= '0;
      rev_q   <= 1'b0;
      presc_q <= '0;
      div_q   <= '0;
    end else begin
      led_q   <= led_d;
      mode_q  <= mode_d;
      run_q   <= run_d;
      fast_q  <= fast_d;
      lmask_q <= lmask_d;
      rmask_q <= rmask_d;
      fill_q  <= fill_d;
      rev_q   <= rev_d;
      presc_q <= presc_d;
      div_q   <= div_d;
    end
  end

  assign led_o  = led_q;
  assign run_o  = run_q;
  assign fast_o = fast_q;
  assign mode_o = mode_q;

endmodule

@@ sv/debounced_led_pattern_sequencer.sv @@
// A result follows its input transfer through two registered steps: the input register, then
// the state update that loads the result registers.
// Throughput: one item per cycle; while a result waits the input register takes one
// more item and then the input stalls.
// Reset (rst_ni low, asynchronous): all state and flags but the held input data cleared, LEDs off, mode idle,
// configuration back to prescale 250, slow 16, fast 8, debounce limit 4.
module debounced_led_pattern_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       opcode_i,
  input  logic       run_button_i,
  input  logic       speed_button_i,
  input  logic       mode_button_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] led_pattern_o,
  output logic       running_o,
  output logic       fast_speed_o,
  output logic [2:0] pattern_mode_o
);
  import dlps_pkg::*;

  cfg_t       cfg_q;
  logic       in_valid_q;
  logic       opcode_q;
  logic [NumButtons-1:0] btn_q;
  logic       out_valid_q, out_valid_d;
  logic       advance, sample_en;
  btn_edge_t  edges;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_prescale  <= RST_TICK_PRESCALE;
      cfg_q.slow_divisor   <= RST_SLOW_DIVISOR;
      cfg_q.fast_divisor   <= RST_FAST_DIVISOR;
      cfg_q.debounce_limit <= RST_DEBOUNCE_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TICK_PRESCALE:  cfg_q.tick_prescale  <= cfg_wdata_i;
        REG_SLOW_DIVISOR:   cfg_q.slow_divisor   <= cfg_wdata_i;
        REG_FAST_DIVISOR:   cfg_q.fast_divisor   <= cfg_wdata_i;
        REG_DEBOUNCE_LIMIT: cfg_q.debounce_limit <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // the held item moves on when the result slot is free or being drained
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  assign sample_en   = advance && (opcode_q == OP_SAMPLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      opcode_q <= opcode_i;
      btn_q    <= {mode_button_i, speed_button_i, run_button_i};
    end
  end

  dlps_debounce u_db_run (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_en),
    .raw_i    (btn_q[0]),
    .limit_i  (cfg_q.debounce_limit),
    .fall_o   (edges.run)
  );

  dlps_debounce u_db_speed (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_en),
    .raw_i    (btn_q[1]),
    .limit_i  (cfg_q.debounce_limit),
    .fall_o   (edges.speed)
  );

  dlps_debounce u_db_mode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_en),
    .raw_i    (btn_q[2]),
    .limit_i  (cfg_q.debounce_limit),
    .fall_o   (edges.mode)
  );

  dlps_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .opcode_i  (opcode_q),
    .edge_i    (edges),
    .cfg_i     (cfg_q),
    .led_o     (led_pattern_o),
    .run_o     (running_o),
    .fast_o    (fast_speed_o),
    .mode_o    (pattern_mode_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

@@ verif/tb_debounced_led_pattern_sequencer.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for debounced_led_pattern_sequencer: a scoreboard class predicts
// every result from the accepted transfers, plain tasks drive buttons, ticks and config.
// Depends on dlps_pkg and the debounced_led_pattern_sequencer RTL.
module tb_debounced_led_pattern_sequencer;
  import dlps_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldOffCycles = 64;

  typedef struct packed {
    logic       opcode;
    logic [2:0] buttons;  // bit 0 run, bit 1 speed, bit 2 mode
  } btn_item_t;

  typedef struct packed {
    logic [7:0] leds;
    logic       running;
    logic       fast;
    logic [2:0] mode;
  } led_state_t;

  class led_pattern_scoreboard;
    cfg_t       cfg;
    logic [7:0] leds;
    logic [7:0] left_bits;
    logic [7:0] right_bits;
    logic [7:0] fill_next;
    logic [7:0] prescale_cnt;
    logic [7:0] step_cnt;
    logic [2:0] mode;
    logic       running;
    logic       fast;
    logic       backing_out;
    logic [2:0] last_raw;
    logic [2:0] level;
    logic [2:0] last_level;
    logic [3:0] same_cnt [3];
    led_state_t expected_leds [$];
    int         mismatches;

    function new();
      int b;
      cfg.tick_prescale  = RST_TICK_PRESCALE;
      cfg.slow_divisor   = RST_SLOW_DIVISOR;
      cfg.fast_divisor   = RST_FAST_DIVISOR;
      cfg.debounce_limit = RST_DEBOUNCE_LIMIT;
      leds         = '0;
      left_bits    = '0;
      right_bits   = '0;
      fill_next    = '0;
      prescale_cnt = '0;
      step_cnt     = '0;
      mode         = MODE_IDLE;
      running      = 1'b0;
      fast         = 1'b0;
      backing_out  = 1'b0;
      last_raw     = '0;
      level        = '0;
      last_level   = '0;
      for (b = 0; b < 3; b++) same_cnt[b] = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] value);
      case (idx)
        REG_TICK_PRESCALE:  cfg.tick_prescale = value;
        REG_SLOW_DIVISOR:   cfg.slow_divisor = value;
        REG_FAST_DIVISOR:   cfg.fast_divisor = value;
        REG_DEBOUNCE_LIMIT: cfg.debounce_limit = value[3:0];
        default: ;
      endcase
    endfunction

    // true when the debounced level of button b goes from 1 to 0
    function bit released(int b, logic raw);
      bit fell;
      if (last_raw[b] != raw) begin
        same_cnt[b] = '0;
      end else begin
        same_cnt[b] = same_cnt[b] + 4'd1;
        if (same_cnt[b] > cfg.debounce_limit) begin
          level[b]    = raw;
          same_cnt[b] = '0;
        end
      end
      fell = last_level[b] & ~level[b];
      last_level[b] = level[b];
      last_raw[b]   = raw;
      return fell;
    endfunction

    function void advance_mode();
      leds = '0;
      mode = (mode >= MODE_FILL) ? MODE_BLINK : mode + 3'd1;
      if (mode == MODE_CONVERGE) begin
        left_bits  = SEED_LEFT;
        right_bits = SEED_RIGHT;
      end else if (mode == MODE_FILL) begin
        backing_out = 1'b0;
        fill_next   = SEED_FILL;
        left_bits   = SEED_LEFT;
        right_bits  = SEED_RIGHT;
      end
    endfunction

    function void pattern_step();
      if (!running) begin
        leds = '0;
        mode = MODE_IDLE;
      end else begin
        case (mode)
          MODE_BLINK: leds = ~leds;
          MODE_WALK:  leds = (leds == '0 || (leds & WALK_LAST) != '0) ? SEED_LEFT : leds << 1;
          MODE_CONVERGE: begin
            // the two lights skip the middle instead of overlapping
            if (left_bits == CONV_PIVOT) begin
              left_bits  = left_bits << 1;
              right_bits = right_bits >> 1;
            end
            leds       = left_bits | right_bits;
            left_bits  = left_bits << 1;
            right_bits = right_bits >> 1;
            if (left_bits == '0) begin
              left_bits  = RESEED_LEFT;
              right_bits = RESEED_RIGHT;
            end
          end
          MODE_FILL: begin
            if (left_bits == '0) begin
              // emptied out: blank one step and start filling again
              right_bits  = SEED_RIGHT;
              fill_next   = SEED_FILL;
              left_bits   = SEED_LEFT;
              leds        = '0;
              backing_out = 1'b0;
            end else begin
              if (left_bits == FILL_TURN) begin
                backing_out = 1'b1;
                right_bits  = right_bits << 2;
                left_bits   = left_bits >> 2;
              end
              leds = left_bits | right_bits;
              if (!backing_out) begin
                left_bits  = {left_bits[6:0], 1'b1};
                right_bits = right_bits | fill_next;
                fill_next  = fill_next >> 1;
              end else begin
                left_bits  = left_bits >> 1;
                right_bits = right_bits << 1;
              end
            end
          end
          default: ;
        endcase
      end
    endfunction

    function void note_item(btn_item_t it);
      logic [7:0] lim;
      if (it.opcode == OP_SAMPLE) begin
        if (released(0, it.buttons[0])) running = ~running;
        if (released(1, it.buttons[1])) fast = ~fast;
        if (released(2, it.buttons[2])) advance_mode();
      end else begin
        prescale_cnt = prescale_cnt + 8'd1;
        if (prescale_cnt >= cfg.tick_prescale) begin
          lim          = fast ? cfg.fast_divisor : cfg.slow_divisor;
          prescale_cnt = '0;
          step_cnt     = step_cnt + 8'd1;
          if (step_cnt >= lim) begin
            step_cnt = '0;
            pattern_step();
          end
        end
      end
      expected_leds.push_back(led_state_t'({leds, running, fast, mode}));
    endfunction

    function void check_leds(led_state_t got);
      led_state_t want;
      if (expected_leds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: leds=%h run=%b fast=%b mode=%0d",
                   got.leds, got.running, got.fast, got.mode);
        return;
      end
      want = expected_leds.pop_front();
      if (got.leds !== want.leds || got.running !== want.running ||
          got.fast !== want.fast || got.mode !== want.mode) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result error: expected leds=%h run=%b fast=%b mode=%0d,",
                   want.leds, want.running, want.fast, want.mode,
                   " got leds=%h run=%b fast=%b mode=%0d",
                   got.leds, got.running, got.fast, got.mode);
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       opcode_i;
  logic       run_button_i;
  logic       speed_button_i;
  logic       mode_button_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] led_pattern_o;
  logic       running_o;
  logic       fast_speed_o;
  logic [2:0] pattern_mode_o;

  led_pattern_scoreboard board;
  logic [2:0] btn_level = '0;
  int         items_sent = 0;
  bit         quiet = 1'b0;
  int         hold_req = 0;
  int         hold_served = 0;
  int         cycles = 0;

  debounced_led_pattern_sequencer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .run_button_i   (run_button_i),
    .speed_button_i (speed_button_i),
    .mode_button_i  (mode_button_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .led_pattern_o  (led_pattern_o),
    .running_o      (running_o),
    .fast_speed_o   (fast_speed_o),
    .pattern_mode_o (pattern_mode_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic cfg_t make_cfg(int pre, int slow_div, int fast_div, int lim);
    cfg_t c;
    c.tick_prescale  = 8'(pre);
    c.slow_divisor   = 8'(slow_div);
    c.fast_divisor   = 8'(fast_div);
    c.debounce_limit = 4'(lim);
    return c;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    board.set_reg(idx, value);
  endtask

  task automatic load_config(cfg_t c);
    write_reg(REG_TICK_PRESCALE, c.tick_prescale);
    write_reg(REG_SLOW_DIVISOR, c.slow_divisor);
    write_reg(REG_FAST_DIVISOR, c.fast_divisor);
    write_reg(REG_DEBOUNCE_LIMIT, {4'd0, c.debounce_limit});
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // stop offering and let every outstanding result drain
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.expected_leds.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic drive_item(btn_item_t it);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 99) < 21) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= it.opcode;
    run_button_i   <= it.buttons[0];
    speed_button_i <= it.buttons[1];
    mode_button_i  <= it.buttons[2];
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(it);
    items_sent++;
  endtask

  task automatic send_sample(logic [2:0] lv);
    drive_item(btn_item_t'({OP_SAMPLE, lv}));
  endtask

  task automatic send_tick();
    // button levels are don't-care on a tick
    drive_item(btn_item_t'({OP_TICK, 3'($urandom)}));
  endtask

  // hold the chosen buttons high, then low, with an optional one-sample bounce in each half
  task automatic press_buttons(logic [2:0] which, int hold, bit bounce);
    int i;
    int glitch_at;
    glitch_at = bounce ? $urandom_range(0, hold - 1) : -1;
    btn_level = btn_level | which;
    for (i = 0; i < hold; i++) send_sample(i == glitch_at ? btn_level & ~which : btn_level);
    glitch_at = bounce ? $urandom_range(0, hold - 1) : -1;
    btn_level = btn_level & ~which;
    for (i = 0; i < hold; i++) send_sample(i == glitch_at ? btn_level | which : btn_level);
  endtask

  task automatic run_random(int quota);
    int stop_at;
    int pick;
    int hold;
    int n;
    logic [2:0] which;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        which = 3'($urandom_range(1, 7));
        if ($urandom_range(0, 2) == 0) which = 3'b100;
        if ($urandom_range(0, 4) == 0)
          hold = $urandom_range(1, board.cfg.debounce_limit + 1);  // too short to register
        else
          hold = board.cfg.debounce_limit + 2 + $urandom_range(0, 2);
        press_buttons(which, hold, $urandom_range(0, 5) == 0);
      end else if (pick < 85) begin
        if ($urandom_range(0, 9) == 0)
          n = $urandom_range(20, 20 + board.cfg.tick_prescale);
        else
          n = $urandom_range(1, 12);
        repeat (n) send_tick();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          btn_level = 3'($urandom);
          send_sample(btn_level);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_leds(led_state_t'({led_pattern_o, running_o, fast_speed_o, pattern_mode_o}));
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_served) begin
        hold_served = hold_req;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= quiet || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("debounced_led_pattern_sequencer: mismatch");
    $finish;
  end

  initial begin
    int   p;
    cfg_t phase_cfg [8];
    int   phase_items [8];
    board          = new();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_TICK_PRESCALE;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_SAMPLE;
    run_button_i   = 1'b0;
    speed_button_i = 1'b0;
    mode_button_i  = 1'b0;
    phase_cfg[0] = make_cfg(1, 1, 1, 1);
    phase_cfg[1] = make_cfg(1, 2, 1, 2);
    phase_cfg[2] = make_cfg(2, 1, 3, 14);
    phase_cfg[3] = make_cfg(1, 255, 1, 3);
    phase_cfg[4] = make_cfg(255, 1, 1, 1);
    phase_cfg[5] = make_cfg(RST_TICK_PRESCALE, RST_SLOW_DIVISOR, RST_FAST_DIVISOR,
                            RST_DEBOUNCE_LIMIT);
    phase_cfg[6] = make_cfg(1, 1, 255, 6);
    phase_cfg[7] = make_cfg(3, 1, 2, 1);
    phase_items  = '{105, 105, 105, 105, 280, 40, 105, 105};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: every tick is a step, three samples settle a level
    load_config(make_cfg(1, 1, 1, 1));
    send_tick();
    press_buttons(3'b111, 3, 1'b0);
    repeat (2) send_tick();
    press_buttons(3'b100, 3, 1'b0);
    repeat (2) send_tick();
    press_buttons(3'b001, 3, 1'b0);
    send_tick();

    for (p = 0; p < 8; p++) begin
      settle();
      load_config(phase_cfg[p]);
      quiet = (p == 1);
      if (p == 2) hold_req++;
      run_random(phase_items[p]);
    end

    settle();
    repeat (4) @(posedge clk_i);
    if (board.mismatches == 0 && board.expected_leds.size() == 0)
      $display("debounced_led_pattern_sequencer: match");
    else
      $display("debounced_led_pattern_sequencer: mismatch");
    $finish;
  end

endmodule
